>>> rtl/cbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Mapper mode codes, bank store layout and the 8 KB slot decode.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned BANK_W   = 8;
  localparam int unsigned NUM_BANK = 4;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned ROM_W    = 22;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_NONE  = 3'd0;
  localparam mode_t MODE_A8    = 3'd1;
  localparam mode_t MODE_A16   = 3'd2;
  localparam mode_t MODE_K4    = 3'd3;
  localparam mode_t MODE_SCC   = 3'd4;
  localparam mode_t MODE_RESET = MODE_A16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic [NUM_BANK-1:0][BANK_W-1:0] bank_vec_t;
  typedef logic [ADDR_W-1:0]               addr_t;
  typedef logic [ROM_W-1:0]                rom_addr_t;

  // 8 KB slot within the 0x4000-0xbfff window: (a[15:13] - 2) mod 4
  function automatic logic [1:0] slot_of(input addr_t a);
    logic [2:0] s;
    s = a[15:13] - 3'd2;
    return s[1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/cbm_bank_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_bank_regs: bank number store with per-mode register decode
// Decodes bank register writes and reloads the banks on a mode write.
// ----------------------------------------------------------------------------
module cbm_bank_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cbm_pkg::mode_t     mode,
  input  wire logic               reload,
  input  wire cbm_pkg::mode_t     reload_mode,
  input  wire logic               wr_en,
  input  wire cbm_pkg::addr_t     wr_addr,
  input  wire logic [7:0]         wr_data,
  output cbm_pkg::bank_vec_t      banks
);

  cbm_pkg::bank_vec_t banks_r, banks_nxt;
  logic               hit;
  logic [1:0]         idx;

  // register address decode
  always_comb begin
    hit = 1'b0;
    idx = 2'd0;
    unique case (mode) inside
      cbm_pkg::MODE_A16: begin
        if (wr_addr == 16'h6000) begin
          hit = 1'b1;
          idx = 2'd0;
        end else if (wr_addr == 16'h7000 || wr_addr == 16'h77ff) begin
          hit = 1'b1;
          idx = 2'd1;
        end
      end
      cbm_pkg::MODE_A8: begin
        hit = (wr_addr[15:13] == 3'b011);
        idx = wr_addr[12:11];
      end
      cbm_pkg::MODE_K4: begin
        hit = (wr_addr[15:13] >= 3'd3) && (wr_addr[15:13] <= 3'd5);
        idx = cbm_pkg::slot_of(wr_addr);
      end
      cbm_pkg::MODE_SCC: begin
        hit = (wr_addr[15:13] >= 3'd2) && (wr_addr[15:13] <= 3'd5) &&
              (wr_addr[12:11] == 2'b10);
        idx = cbm_pkg::slot_of(wr_addr);
      end
      default: begin
        hit = 1'b0;
        idx = 2'd0;
      end
    endcase
  end

  always_comb begin
    banks_nxt = banks_r;
    if (reload) begin
      for (int i = 0; i < cbm_pkg::NUM_BANK; i++) begin
        banks_nxt[i] = (reload_mode == cbm_pkg::MODE_A16) ? '0 : cbm_pkg::BANK_W'(i);
      end
    end else if (wr_en && hit) begin
      banks_nxt[idx] = wr_data;
    end
  end

  // reset state is the reset mode's load: all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r <= '0;
    end else begin
      banks_r <= banks_nxt;
    end
  end

  assign banks = banks_r;

endmodule
`default_nettype wire

>>> rtl/cbm_addr_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_addr_map: read address translation
// Maps a bus address to a ROM byte address or flags it unmapped.
// ----------------------------------------------------------------------------
module cbm_addr_map (
  input  wire cbm_pkg::mode_t     mode,
  input  wire cbm_pkg::bank_vec_t banks,
  input  wire cbm_pkg::addr_t     addr,
  output cbm_pkg::rom_addr_t      rom_address,
  output logic                    unmapped
);

  logic       in_window;
  logic [1:0] slot;
  logic [7:0] bank;

  assign in_window = (addr[15:14] == 2'b01) || (addr[15:14] == 2'b10);
  assign slot      = cbm_pkg::slot_of(addr);

  always_comb begin
    rom_address = '0;
    unmapped    = 1'b0;
    bank        = banks[slot];
    unique case (mode) inside
      cbm_pkg::MODE_A16: begin
        bank        = addr[15] ? banks[1] : banks[0];
        rom_address = {bank, addr[13:0]};
      end
      cbm_pkg::MODE_A8, cbm_pkg::MODE_K4, cbm_pkg::MODE_SCC: begin
        // fixed first slot (bank 0) in the K4 scheme only
        if (mode == cbm_pkg::MODE_K4 && slot == 2'd0) begin
          bank = '0;
        end
        if (in_window) begin
          rom_address = {1'b0, bank, addr[12:0]};
        end else begin
          unmapped = 1'b1;
        end
      end
      default: begin
        if (in_window) begin
          rom_address = {6'd0, addr - 16'h4000};
        end else begin
          unmapped = 1'b1;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/cartridge_bank_mapper.sv
// Path: an accepted read beat is loaded into the input register, then into the
// result register when stage 1 advances, and is shown on the out channel; writes
// give no beat. Throughput: one beat per cycle while out_ready keeps the result
// register moving; the input register drains into the result register whenever
// that register is empty or being taken, writes never wait.
// Reset (synchronous, rst_n low): both stages empty, mode ascii16, banks zero.
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: megarom bank mapper, top level
// Input register, bank store, address translation and result register.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_data,
  // access channel
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_command,
  input  wire logic [15:0]  in_address,
  input  wire logic [7:0]   in_write_data,
  // result channel
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [21:0]       out_rom_address,
  output logic              out_unmapped
);

  cbm_pkg::mode_t     mode_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_cmd_r;
  cbm_pkg::addr_t     s1_addr_r;
  logic [7:0]         s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  cbm_pkg::rom_addr_t out_rom_r;
  logic               out_unmapped_r;

  logic               s1_adv;
  logic               in_fire;
  cbm_pkg::bank_vec_t banks;
  cbm_pkg::rom_addr_t map_rom;
  logic               map_unmapped;

  // Stage 1 moves on when it holds a write (no result slot needed) or the
  // result register is free or being drained this cycle.
  assign s1_adv   = s1_valid_r &&
                    (s1_cmd_r == cbm_pkg::CMD_WRITE || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_cmd_r == cbm_pkg::CMD_READ) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cbm_pkg::MODE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
    end
    if (s1_adv && s1_cmd_r == cbm_pkg::CMD_READ) begin
      out_rom_r      <= map_rom;
      out_unmapped_r <= map_unmapped;
    end
  end

  // bank writes land at the edge the write leaves stage 1, so the next
  // read in stage 1 already sees them
  cbm_bank_regs u_banks (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode        (mode_r),
    .reload      (cfg_we),
    .reload_mode (cfg_data),
    .wr_en       (s1_adv && s1_cmd_r == cbm_pkg::CMD_WRITE),
    .wr_addr     (s1_addr_r),
    .wr_data     (s1_data_r),
    .banks       (banks)
  );

  cbm_addr_map u_map (
    .mode        (mode_r),
    .banks       (banks),
    .addr        (s1_addr_r),
    .rom_address (map_rom),
    .unmapped    (map_unmapped)
  );

  assign out_valid       = out_valid_r;
  assign out_rom_address = out_rom_r;
  assign out_unmapped    = out_unmapped_r;

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // a read leaving stage 1 always lands in the result register
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_cmd_r == cbm_pkg::CMD_READ |=> out_valid_r)
    else $error("read beat lost between stages");

  // a write never creates a result beat
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_cmd_r == cbm_pkg::CMD_WRITE && (!out_valid_r || out_ready)
    |=> !out_valid_r)
    else $error("write beat produced a result");

  // unmapped results carry a zero address
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_unmapped_r |-> out_rom_r == '0)
    else $error("unmapped result with nonzero address");

endmodule
`default_nettype wire
